### src/ppargb_pkg.sv
// Package: shared widths, format codes, register indexes, 4/5/6-to-8 expansion functions.
`timescale 1ns / 1ps
`default_nettype none

package ppargb_pkg;

   localparam int BYTE_W      = 8;
   localparam int CHAN_W      = 8;
   localparam int DIM_W       = 15;
   localparam int FMT_W       = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;
   localparam int HELD_W      = 24;

   typedef enum logic [FMT_W-1:0] {
      FMT_RGB565   = 3'd0,
      FMT_ARGB4444 = 3'd1,
      FMT_RGB888   = 3'd2,
      FMT_ARGB8888 = 3'd3,
      FMT_ARGB1555 = 3'd4
   } src_format_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_FORMAT = 2'd0,
      CSR_IMAGE_WIDTH   = 2'd1,
      CSR_IMAGE_HEIGHT  = 2'd2
   } csr_index_type;

   // Rounded expansion of a 5-bit component to 8 bits.
   function automatic logic [CHAN_W-1:0] expand5(input logic [4:0] v);
      logic [CHAN_W-1:0] r;
      begin
         case (v)
            5'd0:  r = 8'd0;
            5'd1:  r = 8'd8;
            5'd2:  r = 8'd16;
            5'd3:  r = 8'd25;
            5'd4:  r = 8'd33;
            5'd5:  r = 8'd41;
            5'd6:  r = 8'd49;
            5'd7:  r = 8'd58;
            5'd8:  r = 8'd66;
            5'd9:  r = 8'd74;
            5'd10: r = 8'd82;
            5'd11: r = 8'd90;
            5'd12: r = 8'd99;
            5'd13: r = 8'd107;
            5'd14: r = 8'd115;
            5'd15: r = 8'd123;
            5'd16: r = 8'd132;
            5'd17: r = 8'd140;
            5'd18: r = 8'd148;
            5'd19: r = 8'd156;
            5'd20: r = 8'd165;
            5'd21: r = 8'd173;
            5'd22: r = 8'd181;
            5'd23: r = 8'd189;
            5'd24: r = 8'd197;
            5'd25: r = 8'd206;
            5'd26: r = 8'd214;
            5'd27: r = 8'd222;
            5'd28: r = 8'd230;
            5'd29: r = 8'd239;
            5'd30: r = 8'd247;
            default: r = 8'd255;
         endcase
         return r;
      end
   endfunction

   // floor(v * 255 / 63) = 4v + floor(v / 21) for a 6-bit v.
   function automatic logic [CHAN_W-1:0] expand6(input logic [5:0] v);
      logic [1:0] q;
      begin
         if (v >= 6'd63) begin
            q = 2'd3;
         end else if (v >= 6'd42) begin
            q = 2'd2;
         end else if (v >= 6'd21) begin
            q = 2'd1;
         end else begin
            q = 2'd0;
         end
         return {v, 2'b00} + {6'b0, q};
      end
   endfunction

   // v * 17 for a 4-bit v.
   function automatic logic [CHAN_W-1:0] expand4(input logic [3:0] v);
      return {v, v};
   endfunction

endpackage

`default_nettype wire

### src/ppargb_if.sv
// Interfaces: byte request channel and pixel response channel.
`timescale 1ns / 1ps
`default_nettype none

interface ppargb_req_if import ppargb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface ppargb_rsp_if import ppargb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] pixel_red;
   logic [CHAN_W-1:0] pixel_green;
   logic [CHAN_W-1:0] pixel_blue;
   logic [CHAN_W-1:0] pixel_alpha;
   logic              row_end;
   logic              image_end;

   modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                   output pixel_alpha, output row_end, output image_end, input ready);
   modport sink   (input valid, input pixel_red, input pixel_green, input pixel_blue,
                   input pixel_alpha, input row_end, input image_end, output ready);
endinterface

`default_nettype wire

### src/packed_pixel_to_argb8888.sv
// Top level: packed byte stream to ARGB8888 pixel expander.
//
//   channel   dir  handshake          payload
//   req_chan  in   valid/ready        data_byte
//   rsp_chan  out  valid/ready        pixel_red/green/blue/alpha, row_end, image_end
//   csr_*     in   csr_write_enable   csr_index, csr_write_data (no read-back)
//
// One byte is taken per clock unless it completes a pixel while a result waits. A
// pixel's result is loaded at the edge that takes its last byte and offered from
// the next cycle; the conversion is a single pass of table and add logic.
// Reset (synchronous, active high) sets rgb565, 1x1 and an empty pixel, clears the
// position counters and drops any pending transaction; the payload is not reset.
// While a result waits, bytes that do not complete a pixel are still taken;
// the completing byte waits until the result register frees up.
`timescale 1ns / 1ps
`default_nettype none

module packed_pixel_to_argb8888 import ppargb_pkg::*; (
   input  wire                    clock,
   input  wire                    reset,
   ppargb_req_if.sink             req_chan,
   ppargb_rsp_if.source           rsp_chan,
   input  wire                    csr_write_enable,
   input  wire [CSR_INDEX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_write_data
);

   // Configuration registers
   logic [FMT_W-1:0] fmt_ff, fmt_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;

   // Pixel assembly and position state
   logic [1:0]        byte_pos_ff, byte_pos_in;
   logic [HELD_W-1:0] held_ff, held_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [DIM_W-1:0]  row_ff, row_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0] red_ff, red_in;
   logic [CHAN_W-1:0] green_ff, green_in;
   logic [CHAN_W-1:0] blue_ff, blue_in;
   logic [CHAN_W-1:0] alpha_ff, alpha_in;
   logic              row_end_ff, row_end_in;
   logic              image_end_ff, image_end_in;

   logic              fmt_ok;
   logic [1:0]        need_last;
   logic              pixel_done;
   logic              req_accept;
   logic              rsp_free;
   logic [15:0]       word16;
   logic [DIM_W-1:0]  last_col;
   logic [DIM_W-1:0]  last_row;
   logic              hit_row_end;
   logic              hit_image_end;
   logic [4:0]        shift_amt;

   // Index of the byte that completes a pixel; unused codes take no pixel.
   always_comb begin
      fmt_ok    = 1'b1;
      need_last = 2'd1;
      case (fmt_ff)
         FMT_RGB565, FMT_ARGB4444, FMT_ARGB1555: need_last = 2'd1;
         FMT_RGB888:   need_last = 2'd2;
         FMT_ARGB8888: need_last = 2'd3;
         default: begin
            fmt_ok    = 1'b0;
            need_last = 2'd1;
         end
      endcase
   end

   // A position left over from a longer format completes the pixel at once.
   assign pixel_done = fmt_ok && (byte_pos_ff >= need_last);

   // Take non-completing bytes even while a result is stalled.
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = rsp_free || !pixel_done;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // 16-bit word: low byte held, high byte current for two-byte formats.
   assign word16 = {(need_last == 2'd1) ? req_chan.data_byte : held_ff[15:8], held_ff[7:0]};

   // Zero size behaves as one.
   assign last_col = (width_ff == '0) ? '0 : width_ff - 1'b1;
   assign last_row = (height_ff == '0) ? '0 : height_ff - 1'b1;
   assign hit_row_end   = (col_ff >= last_col);
   assign hit_image_end = hit_row_end && (row_ff >= last_row);

   assign shift_amt = {1'b0, byte_pos_ff, 2'b00} << 1;

   // Component expansion
   always_comb begin
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      alpha_in = alpha_ff;
      case (fmt_ff)
         FMT_RGB565: begin
            blue_in  = expand5(word16[4:0]);
            green_in = expand6(word16[10:5]);
            red_in   = expand5(word16[15:11]);
            alpha_in = 8'hFF;
         end
         FMT_ARGB4444: begin
            blue_in  = expand4(word16[3:0]);
            green_in = expand4(word16[7:4]);
            red_in   = expand4(word16[11:8]);
            alpha_in = expand4(word16[15:12]);
         end
         FMT_ARGB1555: begin
            blue_in  = expand5(word16[4:0]);
            green_in = expand5(word16[9:5]);
            red_in   = expand5(word16[14:10]);
            alpha_in = word16[15] ? 8'hFF : 8'h00;
         end
         FMT_RGB888: begin
            blue_in  = held_ff[7:0];
            green_in = held_ff[15:8];
            red_in   = req_chan.data_byte;
            alpha_in = 8'hFF;
         end
         FMT_ARGB8888: begin
            blue_in  = held_ff[7:0];
            green_in = held_ff[15:8];
            red_in   = held_ff[23:16];
            alpha_in = req_chan.data_byte;
         end
         default: begin
            red_in   = red_ff;
            green_in = green_ff;
            blue_in  = blue_ff;
            alpha_in = alpha_ff;
         end
      endcase
      row_end_in   = hit_row_end;
      image_end_in = hit_image_end;
   end

   // Assembly, position counters and result valid
   always_comb begin
      byte_pos_in  = byte_pos_ff;
      held_in      = held_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && fmt_ok) begin
         if (pixel_done) begin
            byte_pos_in  = 2'd0;
            held_in      = '0;
            rsp_valid_in = 1'b1;
            if (hit_row_end) begin
               col_in = '0;
               row_in = hit_image_end ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end else begin
            // Hold the byte at its place and advance.
            held_in     = held_ff | ({{(HELD_W-BYTE_W){1'b0}}, req_chan.data_byte} << shift_amt);
            byte_pos_in = byte_pos_ff + 1'b1;
         end
      end
   end

   // Configuration writes
   always_comb begin
      fmt_in    = fmt_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SOURCE_FORMAT: fmt_in    = csr_write_data[FMT_W-1:0];
            CSR_IMAGE_WIDTH:   width_in  = csr_write_data[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:  height_in = csr_write_data[DIM_W-1:0];
            default: begin
               fmt_in = fmt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff       <= FMT_RGB565;
         width_ff     <= DIM_W'(1);
         height_ff    <= DIM_W'(1);
         byte_pos_ff  <= 2'd0;
         held_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fmt_ff       <= fmt_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         byte_pos_ff  <= byte_pos_in;
         held_ff      <= held_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the payload only with a completed pixel.
   always_ff @(posedge clock) begin
      if (req_accept && pixel_done) begin
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         alpha_ff     <= alpha_in;
         row_end_ff   <= row_end_in;
         image_end_ff <= image_end_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pixel_red   = red_ff;
   assign rsp_chan.pixel_green = green_ff;
   assign rsp_chan.pixel_blue  = blue_ff;
   assign rsp_chan.pixel_alpha = alpha_ff;
   assign rsp_chan.row_end     = row_end_ff;
   assign rsp_chan.image_end   = image_end_ff;

   // A completed pixel leaves an empty assembly register.
   a_clear_after_pixel : assert property (@(posedge clock) disable iff (reset)
      (req_accept && pixel_done) |=> (byte_pos_ff == 2'd0 && held_ff == '0))
      else $error("assembly state not cleared after pixel");

   // The last pixel of the image also ends its row.
   a_image_end_row_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!image_end_ff || row_end_ff))
      else $error("image_end without row_end");

   // A new result only follows a taken byte.
   a_rsp_from_req : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept && pixel_done))
      else $error("response raised without a completing byte");

   // With nothing pending, bytes are always taken.
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("input stalled with an empty result register");

   // A row end wraps the column counter.
   a_col_wrap : assert property (@(posedge clock) disable iff (reset)
      (req_accept && pixel_done && hit_row_end) |=> (col_ff == '0))
      else $error("column counter did not wrap at row end");

endmodule

`default_nettype wire
